// ===== rtl/atpf_pkg.sv =====
// Shared types, widths and constants of the adaptive type-of-service packet filter.
package atpf_pkg;

    localparam int LEN_W        = 16;
    localparam int TOS_W        = 8;
    localparam int PROTO_W      = 8;
    localparam int CNT_W        = 32;
    localparam int SUM_W        = 40;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_FIELDS_W = 1 + TOS_W + CNT_W + SUM_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;
    localparam int STEP_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENIENT_MAX  = 8'd3;

    localparam logic [LEN_W-1:0] RESET_MIN_LENGTH   = 16'd36;
    localparam logic [TOS_W-1:0] RESET_WARMUP_COUNT = 8'd5;
    localparam logic [TOS_W-1:0] RESET_TOLERANCE    = 8'd64;
    localparam logic [TOS_W-1:0] RESET_LENIENT_MAX  = 8'd192;

    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [TOS_W-1:0] AVG_MAX   = '1;

    typedef struct packed {
        logic [LEN_W-1:0] min_length;
        logic [TOS_W-1:0] warmup_count;
        logic [TOS_W-1:0] tolerance;
        logic [TOS_W-1:0] lenient_max;
    } cfg_t;

    typedef struct packed {
        logic             is_short;
        logic             proto_ok;
        logic [TOS_W-1:0] tos;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_RANGE,
        ST_STEP,
        ST_AVERAGE,
        ST_FINISH
    } back_state_t;

endpackage

// ===== rtl/adaptive_tos_packet_filter.sv =====
// Top level of the adaptive type-of-service packet filter: configuration registers and stages.
//
// Usage
//   Input channel s_axis_*: one packet header summary per item (length, tos byte,
//   protocol byte). Output channel m_axis_*: exactly one result per input item, in
//   order: accept flag, average tos, packet count and tos sum after that item.
//   Configuration channel cfg_*: writes register cfg_index with cfg_data; it is always
//   ready. Index 0 min_length, 1 warmup_count, 2 tolerance, 3 lenient_max; other
//   indexes are ignored. Write only while no item is in flight.
// Back stage sequence
//   A counted packet passes the back stage as pop, count/sum update, range check,
//   eight restoring-division steps of the 40-by-32 bit average divider, the average
//   write and the result load. A short packet goes from the update straight to the
//   result load; a saturated average skips the division steps. The back stage pops
//   a new item only after it has loaded the result of the last one.
// Reset
//   rst_n clears count, sum and average, loads default configuration (36, 5, 64, 192)
//   and empties the front register, queue and output register.
// Stalls
//   When m_axis_tready is low the result holds in the output register; the back stage
//   stops at its result load, the two-entry queue and front register fill, and then
//   s_axis_tready drops.
module adaptive_tos_packet_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] packet_length, [23:16] tos_value, [31:24] protocol_number
    input  logic [atpf_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [0] accept, [8:1] average_tos, [40:9] count_seen, [80:41] tos_total, [87:81] zero
    output logic [atpf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [atpf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [atpf_pkg::CFG_DATA_W-1:0]        cfg_data
);

    atpf_pkg::cfg_t  cfg_reg;
    logic            push_valid;
    logic            push_ready;
    atpf_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    atpf_pkg::item_t pop_item;

    assign cfg_ready = 1'b1;

    // Register file: decode the index, ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length   <= atpf_pkg::RESET_MIN_LENGTH;
            cfg_reg.warmup_count <= atpf_pkg::RESET_WARMUP_COUNT;
            cfg_reg.tolerance    <= atpf_pkg::RESET_TOLERANCE;
            cfg_reg.lenient_max  <= atpf_pkg::RESET_LENIENT_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                atpf_pkg::REG_MIN_LENGTH:   cfg_reg.min_length   <= cfg_data;
                atpf_pkg::REG_WARMUP_COUNT: cfg_reg.warmup_count <= cfg_data[7:0];
                atpf_pkg::REG_TOLERANCE:    cfg_reg.tolerance    <= cfg_data[7:0];
                atpf_pkg::REG_LENIENT_MAX:  cfg_reg.lenient_max  <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    // Front: classify and register the incoming item
    atpf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    // Queue: decouple front acceptance from the multi-cycle back stage
    atpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: state update, average division, decision, output register
    atpf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/atpf_front.sv =====
// Front stage: accept an input item, classify its length and protocol, hand it to the queue.
module atpf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  atpf_pkg::cfg_t                      cfg,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [atpf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                push_valid,
    input  logic                                push_ready,
    output atpf_pkg::item_t                     push_item
);

    logic [atpf_pkg::LEN_W-1:0]   len;
    logic [atpf_pkg::TOS_W-1:0]   tos;
    logic [atpf_pkg::PROTO_W-1:0] proto;
    atpf_pkg::item_t              item_next;
    atpf_pkg::item_t              item_reg;
    logic                         valid_reg;
    logic                         in_acc;

    assign len   = s_axis_tdata[15:0];
    assign tos   = s_axis_tdata[23:16];
    assign proto = s_axis_tdata[31:24];

    always_comb
    begin
        item_next.is_short = (len < cfg.min_length);
        item_next.proto_ok = (proto == atpf_pkg::PROTO_TCP) ||
                             (proto == atpf_pkg::PROTO_UDP) ||
                             (proto == atpf_pkg::PROTO_ICMP);
        item_next.tos      = tos;
    end

    assign s_axis_tready = !valid_reg || push_ready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign push_valid    = valid_reg;
    assign push_item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/atpf_queue.sv =====
// Two-entry queue of classified items between the front and back stages.
module atpf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  atpf_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output atpf_pkg::item_t pop_item
);

    atpf_pkg::item_t             mem_reg [atpf_pkg::QUEUE_DEPTH];
    logic [atpf_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [atpf_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [atpf_pkg::QCNT_W-1:0] fill_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (fill_reg != atpf_pkg::QCNT_W'(atpf_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/atpf_back.sv =====
// Back stage: update count and sum, divide for the average, decide and register the result.
module atpf_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  atpf_pkg::cfg_t                      cfg,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  atpf_pkg::item_t                     pop_item,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [atpf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    atpf_pkg::back_state_t        state_reg;
    atpf_pkg::back_state_t        state_next;
    atpf_pkg::item_t              item_reg;
    logic [atpf_pkg::CNT_W-1:0]   cnt_reg;
    logic [atpf_pkg::SUM_W-1:0]   sum_reg;
    logic [atpf_pkg::TOS_W-1:0]   avg_reg;
    logic [atpf_pkg::SUM_W-1:0]   rem_reg;
    logic [atpf_pkg::SUM_W-1:0]   div_reg;
    logic [atpf_pkg::TOS_W-1:0]   quo_reg;
    logic [atpf_pkg::STEP_W-1:0]  step_reg;
    logic                         out_valid_reg;
    logic [atpf_pkg::OUT_FIELDS_W-1:0] out_reg;

    logic [atpf_pkg::CNT_W-1:0]   cnt_inc;
    logic [atpf_pkg::SUM_W:0]     sum_wide;
    logic [atpf_pkg::SUM_W-1:0]   sum_add;
    logic [atpf_pkg::SUM_W-1:0]   range_limit;
    logic                         avg_overflow;
    logic                         fits;
    logic [atpf_pkg::TOS_W-1:0]   diff;
    logic                         warm_done;
    logic                         tos_ok;
    logic                         acc;
    logic                         out_free;
    logic                         out_load;

    // Saturating count and sum update
    assign cnt_inc     = (cnt_reg == atpf_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign sum_wide    = {1'b0, sum_reg} + (atpf_pkg::SUM_W + 1)'(item_reg.tos);
    assign sum_add     = sum_wide[atpf_pkg::SUM_W] ? atpf_pkg::SUM_MAX
                                                   : sum_wide[atpf_pkg::SUM_W-1:0];

    // Quotient above 255 only when sum >= count * 256
    assign range_limit  = {cnt_reg, {atpf_pkg::TOS_W{1'b0}}};
    assign avg_overflow = (sum_reg >= range_limit);
    assign fits         = (rem_reg >= div_reg);

    // Acceptance check against the new average
    assign diff      = (item_reg.tos >= avg_reg) ? item_reg.tos - avg_reg
                                                 : avg_reg - item_reg.tos;
    assign warm_done = (cnt_reg >= atpf_pkg::CNT_W'(cfg.warmup_count));
    assign tos_ok    = warm_done ? (diff <= cfg.tolerance) : (item_reg.tos <= cfg.lenient_max);
    assign acc       = !item_reg.is_short && item_reg.proto_ok && tos_ok;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        pop_ready = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            atpf_pkg::ST_IDLE:   pop_ready = 1'b1;
            atpf_pkg::ST_FINISH: out_load  = out_free;
            default:             ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atpf_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = atpf_pkg::ST_UPDATE;
                end
            end
            atpf_pkg::ST_UPDATE:
            begin
                state_next = item_reg.is_short ? atpf_pkg::ST_FINISH : atpf_pkg::ST_RANGE;
            end
            atpf_pkg::ST_RANGE:
            begin
                state_next = avg_overflow ? atpf_pkg::ST_AVERAGE : atpf_pkg::ST_STEP;
            end
            atpf_pkg::ST_STEP:
            begin
                if (step_reg == '0)
                begin
                    state_next = atpf_pkg::ST_AVERAGE;
                end
            end
            atpf_pkg::ST_AVERAGE:
            begin
                state_next = atpf_pkg::ST_FINISH;
            end
            atpf_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = atpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = atpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atpf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == atpf_pkg::ST_UPDATE && !item_reg.is_short)
            begin
                cnt_reg <= cnt_inc;
                sum_reg <= sum_add;
            end
            if (state_reg == atpf_pkg::ST_AVERAGE)
            begin
                avg_reg <= quo_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider datapath and payload registers
    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            item_reg <= pop_item;
        end
        case (state_reg)
            atpf_pkg::ST_RANGE:
            begin
                rem_reg  <= sum_reg;
                div_reg  <= {1'b0, cnt_reg, {(atpf_pkg::TOS_W-1){1'b0}}};
                quo_reg  <= avg_overflow ? atpf_pkg::AVG_MAX : '0;
                step_reg <= atpf_pkg::STEP_W'(atpf_pkg::TOS_W - 1);
            end
            atpf_pkg::ST_STEP:
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - div_reg;
                end
                quo_reg  <= {quo_reg[atpf_pkg::TOS_W-2:0], fits};
                div_reg  <= div_reg >> 1;
                step_reg <= step_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_reg <= {sum_reg, cnt_reg, avg_reg, acc};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = atpf_pkg::OUT_TDATA_W'(out_reg);

endmodule

// ===== rtl/atpf_checker.sv =====
// Port-level checker of the packet filter, bound to the top level.
module atpf_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [atpf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic [3:0]                  pending_reg;
    logic [3:0]                  pending_next;
    logic                        in_acc;
    logic                        out_acc;
    logic [atpf_pkg::CNT_W-1:0]  count_f;
    logic [atpf_pkg::SUM_W-1:0]  total_f;
    logic [atpf_pkg::SUM_W-1:0]  total_bound;

    assign in_acc       = s_axis_tvalid && s_axis_tready;
    assign out_acc      = m_axis_tvalid && m_axis_tready;
    assign pending_next = pending_reg + 4'(in_acc) - 4'(out_acc);
    assign count_f      = m_axis_tdata[40:9];
    assign total_f      = m_axis_tdata[80:41];
    assign total_bound  = atpf_pkg::SUM_W'(count_f) * atpf_pkg::SUM_W'(255);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    // Never show a result without an accepted item behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 4'd0)
        else $error("result without an input item");

    // Nothing counted means empty sum, zero average, drop
    a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && count_f == '0 |->
            total_f == '0 && m_axis_tdata[8:1] == '0 && !m_axis_tdata[0])
        else $error("nonzero result with no counted packet");

    // Sum cannot exceed 255 per counted packet before the count saturates
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && count_f != atpf_pkg::COUNT_MAX |-> total_f <= total_bound)
        else $error("tos sum exceeds count times 255");

endmodule

bind adaptive_tos_packet_filter atpf_checker u_atpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/adaptive_tos_packet_filter_tb.sv =====
// Self-checking stream testbench for the adaptive type-of-service packet filter.
`timescale 1ns / 1ps

module adaptive_tos_packet_filter_tb;

    import atpf_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DIRECTED_ROWS   = 19;

    // Indexes past the register file; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    // One result item, laid out as in m_axis_tdata (accept in bit 0).
    typedef struct packed {
        logic [SUM_W-1:0] tos_total;
        logic [CNT_W-1:0] count_seen;
        logic [TOS_W-1:0] average_tos;
        logic             accept;
    } verdict_t;

    // One directed header; typed rows carry a hand-worked verdict.
    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [TOS_W-1:0]   tos;
        logic [PROTO_W-1:0] proto;
        logic               typed;
        verdict_t           want;
    } header_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Hand-worked verdict that travels alongside the header being offered.
    logic                   typed_on = 1'b0;
    verdict_t               typed_verdict = '0;

    // Shadow of the filter: its registers and its running statistics.
    logic [LEN_W-1:0]       min_len_r = RESET_MIN_LENGTH;
    logic [TOS_W-1:0]       warmup_r = RESET_WARMUP_COUNT;
    logic [TOS_W-1:0]       tol_r = RESET_TOLERANCE;
    logic [TOS_W-1:0]       lenient_r = RESET_LENIENT_MAX;
    logic [CNT_W-1:0]       pkt_count = '0;
    logic [SUM_W-1:0]       tos_sum = '0;
    logic [TOS_W-1:0]       tos_avg = '0;

    verdict_t               pending_verdicts[$];
    int                     mismatches = 0;
    int                     headers_sent = 0;
    int                     verdicts_checked = 0;
    int                     cycles = 0;
    int                     send_pct = 0;
    int                     stall_pct = 0;

    int                     len_i;
    int                     tos_i;
    int                     proto_i;

    // Directed headers under reset settings (min 36, warm-up 5, tolerance 64,
    // lenient 192). The first eight rows are worked by hand.
    header_row_t directed_rows [DIRECTED_ROWS] = '{
        // zero length and one below the minimum: dropped, state untouched
        '{16'd0,     8'd255, PROTO_TCP,  1'b1, '{40'd0,   32'd0, 8'd0,   1'b0}},
        '{16'd35,    8'd0,   PROTO_UDP,  1'b1, '{40'd0,   32'd0, 8'd0,   1'b0}},
        // exactly the minimum, warm-up with tos at its floor
        '{16'd36,    8'd0,   PROTO_ICMP, 1'b1, '{40'd0,   32'd1, 8'd0,   1'b1}},
        // longest packet, tos right at the lenient ceiling
        '{16'd65535, 8'd192, PROTO_UDP,  1'b1, '{40'd192, 32'd2, 8'd96,  1'b1}},
        // one above the lenient ceiling
        '{16'd100,   8'd193, PROTO_TCP,  1'b1, '{40'd385, 32'd3, 8'd128, 1'b0}},
        // good tos, unknown protocol
        '{16'd1500,  8'd160, 8'd0,       1'b1, '{40'd545, 32'd4, 8'd136, 1'b0}},
        // count reaches the warm-up count: the average check takes over
        '{16'd40,    8'd175, PROTO_TCP,  1'b1, '{40'd720, 32'd5, 8'd144, 1'b1}},
        '{16'd36,    8'd208, PROTO_ICMP, 1'b1, '{40'd928, 32'd6, 8'd154, 1'b1}},
        // far from the average on both sides
        '{16'd255,   8'd0,   PROTO_UDP,  1'b0, '0},
        '{16'h8000,  8'd255, PROTO_TCP,  1'b0, '0},
        // protocol neighbors of the accepted three
        '{16'd37,    8'd130, 8'd2,       1'b0, '0},
        '{16'd36,    8'd140, 8'd5,       1'b0, '0},
        '{16'd36,    8'd140, 8'd7,       1'b0, '0},
        '{16'd36,    8'd140, 8'd16,      1'b0, '0},
        '{16'd36,    8'd140, 8'd18,      1'b0, '0},
        '{16'd36,    8'd140, 8'd255,     1'b0, '0},
        // short packet after warm-up
        '{16'd34,    8'd200, PROTO_UDP,  1'b0, '0},
        '{16'hFFFE,  8'd85,  PROTO_TCP,  1'b0, '0},
        '{16'h00FF,  8'd170, PROTO_ICMP, 1'b0, '0}
    };

    adaptive_tos_packet_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [15:0] packet_length, [23:16] tos_value, [31:24] protocol_number
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] accept, [8:1] average_tos, [40:9] count_seen, [80:41] tos_total
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the shadow statistics by one header and return its verdict.
    function automatic verdict_t tos_filter_step(input logic [LEN_W-1:0] len,
                                                 input logic [TOS_W-1:0] tos,
                                                 input logic [PROTO_W-1:0] proto);
        verdict_t         v;
        logic [SUM_W-1:0] quot;
        logic [TOS_W-1:0] tos_dist;
        logic             proto_ok;
        logic             tos_ok;
        v.accept = 1'b0;
        if (len >= min_len_r)
        begin
            if (pkt_count != COUNT_MAX)
                pkt_count = pkt_count + 1'b1;
            if (tos_sum <= SUM_MAX - SUM_W'(tos))
                tos_sum = tos_sum + SUM_W'(tos);
            else
                tos_sum = SUM_MAX;
            quot = tos_sum / SUM_W'(pkt_count);
            tos_avg = (quot > SUM_W'(AVG_MAX)) ? AVG_MAX : quot[TOS_W-1:0];
            proto_ok = (proto == PROTO_TCP) || (proto == PROTO_UDP) ||
                       (proto == PROTO_ICMP);
            if (pkt_count >= CNT_W'(warmup_r))
            begin
                tos_dist = (tos >= tos_avg) ? tos - tos_avg : tos_avg - tos;
                tos_ok = (tos_dist <= tol_r);
            end
            else
                tos_ok = (tos <= lenient_r);
            v.accept = proto_ok && tos_ok;
        end
        v.average_tos = tos_avg;
        v.count_seen  = pkt_count;
        v.tos_total   = tos_sum;
        return v;
    endfunction

    // Offer one header and hold it until the filter takes it. Valid stays high
    // into the next header unless a sender gap is drawn.
    task automatic send_header(input logic [LEN_W-1:0] len,
                               input logic [TOS_W-1:0] tos,
                               input logic [PROTO_W-1:0] proto,
                               input logic typed,
                               input verdict_t want);
        int gap;
        if (send_pct != 0 && $urandom_range(99) < send_pct)
        begin
            gap = $urandom_range(30, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {proto, tos, len};
        typed_on      <= typed;
        typed_verdict <= want;
        do @(posedge clk); while (!s_axis_tready);
        headers_sent++;
    endtask

    // Write one register and mirror it; valid is lowered by the caller.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MIN_LENGTH:   min_len_r = data;
            REG_WARMUP_COUNT: warmup_r  = data[TOS_W-1:0];
            REG_TOLERANCE:    tol_r     = data[TOS_W-1:0];
            REG_LENIENT_MAX:  lenient_r = data[TOS_W-1:0];
            default: ;
        endcase
    endtask

    // Wait for every outstanding verdict, then let the back stage go quiet.
    // Wait for an edge first so the header taken on this edge is already queued.
    task automatic settle();
        @(posedge clk);
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: stall at random when the phase asks for it, else always ready.
    always @(posedge clk)
    begin
        if (stall_pct != 0)
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        else
            m_axis_tready <= 1'b1;
    end

    // Input side: every accepted header advances the shadow and queues its verdict.
    always @(posedge clk)
    begin : watch_headers
        verdict_t v;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            v = tos_filter_step(s_axis_tdata[15:0], s_axis_tdata[23:16],
                                s_axis_tdata[31:24]);
            if (typed_on)
                v = typed_verdict;
            pending_verdicts.push_back(v);
        end
    end

    // Output side: compare each accepted result with the oldest verdict.
    always @(posedge clk)
    begin : watch_verdicts
        verdict_t got;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_FIELDS_W-1:0];
            if (pending_verdicts.size() == 0)
            begin
                $error("result item with no header waiting: %h", got);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (got.accept !== want.accept)
                begin
                    $error("accept: expected %0d, got %0d", want.accept, got.accept);
                    mismatches++;
                end
                if (got.average_tos !== want.average_tos)
                begin
                    $error("average_tos: expected %0d, got %0d",
                           want.average_tos, got.average_tos);
                    mismatches++;
                end
                if (got.count_seen !== want.count_seen)
                begin
                    $error("count_seen: expected %0d, got %0d",
                           want.count_seen, got.count_seen);
                    mismatches++;
                end
                if (got.tos_total !== want.tos_total)
                begin
                    $error("tos_total: expected %0d, got %0d",
                           want.tos_total, got.tos_total);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        // Hold reset, then release it on an edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            // Idle pattern cycles through: none, sender gaps, receiver stalls, both.
            case (p % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 67; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 67; end
                default: begin send_pct = 36; stall_pct = 36; end
            endcase

            if (p == 0)
            begin
                // Reset settings: walk the directed headers first.
                for (int r = 0; r < DIRECTED_ROWS; r++)
                    send_header(directed_rows[r].len, directed_rows[r].tos,
                                directed_rows[r].proto, directed_rows[r].typed,
                                directed_rows[r].want);
            end
            else
            begin
                // Drain the filter before touching its registers.
                s_axis_tvalid <= 1'b0;
                settle();
                case (p)
                    1:
                    begin
                        // Low extremes with the longest warm-up; stray indexes ignored.
                        write_reg(REG_MIN_LENGTH, 16'd0);
                        write_reg(REG_UNUSED_LO, 16'hFFFF);
                        write_reg(REG_WARMUP_COUNT, {8'hA5, 8'd255});
                        write_reg(REG_TOLERANCE, {8'h5A, 8'd0});
                        write_reg(REG_LENIENT_MAX, {8'hFF, 8'd0});
                        write_reg(REG_UNUSED_HI, 16'h0000);
                    end
                    2:
                    begin
                        // High extremes; a zero warm-up checks the average at once.
                        write_reg(REG_MIN_LENGTH, 16'hFFFF);
                        write_reg(REG_WARMUP_COUNT, 16'd0);
                        write_reg(REG_TOLERANCE, 16'd255);
                        write_reg(REG_LENIENT_MAX, 16'd255);
                    end
                    3:
                    begin
                        write_reg(REG_MIN_LENGTH, RESET_MIN_LENGTH);
                        write_reg(REG_WARMUP_COUNT, 16'(RESET_WARMUP_COUNT));
                        write_reg(REG_TOLERANCE, 16'(RESET_TOLERANCE));
                        write_reg(REG_LENIENT_MAX, 16'(RESET_LENIENT_MAX));
                    end
                    default:
                    begin
                        // Random settings; mostly short minimums so most packets count.
                        write_reg(REG_MIN_LENGTH, (p == PHASES - 1) ?
                                  16'($urandom) : 16'($urandom_range(120)));
                        write_reg(REG_WARMUP_COUNT, 16'($urandom));
                        write_reg(REG_TOLERANCE, 16'($urandom));
                        write_reg(REG_LENIENT_MAX, 16'($urandom));
                    end
                endcase
                cfg_valid <= 1'b0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Length: anywhere, on the minimum, just under it, or a bit over.
                case ($urandom_range(3))
                    0: len_i = $urandom_range(65535);
                    1: len_i = min_len_r;
                    2: len_i = int'(min_len_r) - 1;
                    default: len_i = int'(min_len_r) + $urandom_range(1500);
                endcase
                if (len_i < 0)
                    len_i = 0;
                if (len_i > 65535)
                    len_i = 65535;

                // Tos: anywhere, on either edge of the tolerance band, or the
                // lenient ceiling and the byte extremes.
                case ($urandom_range(4))
                    0, 1: tos_i = $urandom_range(255);
                    2: tos_i = int'(tos_avg) + int'(tol_r) + $urandom_range(1);
                    3: tos_i = int'(tos_avg) - int'(tol_r) - $urandom_range(1);
                    default:
                        case ($urandom_range(2))
                            0: tos_i = int'(lenient_r) + $urandom_range(1);
                            1: tos_i = 0;
                            default: tos_i = 255;
                        endcase
                endcase
                if (tos_i < 0)
                    tos_i = 0;
                if (tos_i > 255)
                    tos_i = 255;

                case ($urandom_range(4))
                    0: proto_i = PROTO_ICMP;
                    1: proto_i = PROTO_TCP;
                    2: proto_i = PROTO_UDP;
                    default: proto_i = $urandom_range(255);
                endcase

                send_header(LEN_W'(len_i), TOS_W'(tos_i), PROTO_W'(proto_i), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        settle();

        $display("summary: %0d headers over %0d register settings and four idle patterns,",
                 headers_sent, PHASES);
        $display("summary: %0d results compared, %0d packets counted, %0d mismatches",
                 verdicts_checked, pkt_count, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
